// ===== rtl/poxseq_pkg.sv =====
package poxseq_pkg;

	// Field widths
	localparam int SLOT_W   = 5;
	localparam int SAMPLE_W = 16;
	localparam int CMP_W    = 4;
	localparam int GAIN_W   = 3;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// Default frame length in ticks
	localparam int SLOTS_PER_FRAME_DEFAULT = 20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RED_PULSE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IR_PULSE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SELECT     = 2'd2;

	// Configuration reset values
	localparam logic [CMP_W-1:0]  RED_PULSE_WIDTH_RST = 4'd4;
	localparam logic [CMP_W-1:0]  IR_PULSE_WIDTH_RST  = 4'd5;
	localparam logic [GAIN_W-1:0] GAIN_SELECT_RST     = 3'd5;

	// Slot actions
	localparam logic [SLOT_W-1:0] SLOT_AMBIENT    = 5'd1;
	localparam logic [SLOT_W-1:0] SLOT_RED_ON     = 5'd2;
	localparam logic [SLOT_W-1:0] SLOT_RED_SAMPLE = 5'd5;
	localparam logic [SLOT_W-1:0] SLOT_RED_OFF    = 5'd6;
	localparam logic [SLOT_W-1:0] SLOT_IR_ON      = 5'd10;
	localparam logic [SLOT_W-1:0] SLOT_IR_SAMPLE  = 5'd13;
	localparam logic [SLOT_W-1:0] SLOT_IR_OFF     = 5'd14;

	// Sequencer state, also the visible part of a result
	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [SAMPLE_W-1:0] ambient;
		logic [SAMPLE_W-1:0] red_level;
		logic [SAMPLE_W-1:0] ir_level;
		logic [CNT_W-1:0]    red_count;
		logic [CNT_W-1:0]    ir_count;
		logic [CMP_W-1:0]    led_compare;
		logic                red_on;
		logic                ir_on;
	} seq_state_t;

	// Pulse widths handed to the step logic
	typedef struct packed {
		logic [CMP_W-1:0] red_pw;
		logic [CMP_W-1:0] ir_pw;
	} pulse_cfg_t;

endpackage

// ===== rtl/poxseq_step.sv =====
module poxseq_step #(
	parameter int SLOTS_PER_FRAME = poxseq_pkg::SLOTS_PER_FRAME_DEFAULT
) (
	input  poxseq_pkg::seq_state_t             cur,
	input  poxseq_pkg::pulse_cfg_t             pulse,
	input  logic [poxseq_pkg::SAMPLE_W-1:0]    sample,
	output poxseq_pkg::seq_state_t             nxt
);
	import poxseq_pkg::*;

	localparam logic [SLOT_W:0] FRAME_LEN = (SLOT_W+1)'(SLOTS_PER_FRAME);

	logic [SLOT_W:0]     slot_inc;
	logic [SLOT_W-1:0]   slot_nxt;
	logic [SAMPLE_W-1:0] level;

	// Advance the slot counter and wrap at the frame length
	assign slot_inc = {1'b0, cur.slot} + {{SLOT_W{1'b0}}, 1'b1};
	assign slot_nxt = (slot_inc >= FRAME_LEN) ? '0 : slot_inc[SLOT_W-1:0];

	// Subtract ambient, clamp at zero
	assign level = (sample >= cur.ambient) ? (sample - cur.ambient) : '0;

	// Apply this slot's action
	always_comb begin
		nxt      = cur;
		nxt.slot = slot_nxt;
		case (slot_nxt)
			SLOT_AMBIENT: begin
				nxt.ambient = sample;
			end
			SLOT_RED_ON: begin
				nxt.led_compare = pulse.red_pw;
				nxt.red_on      = 1'b1;
			end
			SLOT_RED_SAMPLE: begin
				nxt.red_level = level;
				nxt.red_count = cur.red_count + CNT_W'(1);
			end
			SLOT_RED_OFF: begin
				nxt.led_compare = '0;
				nxt.red_on      = 1'b0;
			end
			SLOT_IR_ON: begin
				nxt.led_compare = pulse.ir_pw;
				nxt.ir_on       = 1'b1;
			end
			SLOT_IR_SAMPLE: begin
				nxt.ir_level = level;
				nxt.ir_count = cur.ir_count + CNT_W'(1);
			end
			SLOT_IR_OFF: begin
				nxt.led_compare = '0;
				nxt.ir_on       = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/pulse_oximeter_led_sample_sequencer_unit.sv =====
// A tick's result is registered and offered in the cycle after the tick is accepted.
// Throughput: one tick per cycle unless out_ready is held low; the slot action is a
// single subtract and compare between the state registers and the result register.
// Reset (arst_n low, asynchronous): slot counter, ambient, levels, counts, LED drive
// and output valid clear to zero; pulse widths return to 4 and 5, gain select to 5.
module pulse_oximeter_led_sample_sequencer_unit #(
	parameter int SLOTS_PER_FRAME = poxseq_pkg::SLOTS_PER_FRAME_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [poxseq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [poxseq_pkg::CFG_DATA_W-1:0]   cfg_data,
	// tick input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [poxseq_pkg::SAMPLE_W-1:0]     adc_sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [poxseq_pkg::SLOT_W-1:0]       slot,
	output logic [poxseq_pkg::CMP_W-1:0]        led_compare,
	output logic                                red_enable,
	output logic                                ir_enable,
	output logic [poxseq_pkg::SAMPLE_W-1:0]     red_level,
	output logic [poxseq_pkg::SAMPLE_W-1:0]     ir_level,
	output logic [poxseq_pkg::CNT_W-1:0]        red_count,
	output logic [poxseq_pkg::CNT_W-1:0]        ir_count,
	output logic [poxseq_pkg::GAIN_W-1:0]       gain_pins
);
	import poxseq_pkg::*;

	logic [CMP_W-1:0]  red_pw_q;
	logic [CMP_W-1:0]  ir_pw_q;
	logic [GAIN_W-1:0] gain_q;
	seq_state_t        state_q;
	seq_state_t        state_nxt;
	pulse_cfg_t        pulse;
	seq_state_t        res_q;
	logic [GAIN_W-1:0] res_gain_q;
	logic              out_valid_q;
	logic              in_fire;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_pw_q <= RED_PULSE_WIDTH_RST;
			ir_pw_q  <= IR_PULSE_WIDTH_RST;
			gain_q   <= GAIN_SELECT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RED_PULSE_WIDTH: red_pw_q <= cfg_data;
				CFG_IR_PULSE_WIDTH:  ir_pw_q  <= cfg_data;
				CFG_GAIN_SELECT:     gain_q   <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Accept a tick whenever the result register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign pulse.red_pw = red_pw_q;
	assign pulse.ir_pw  = ir_pw_q;

	poxseq_step #(
		.SLOTS_PER_FRAME(SLOTS_PER_FRAME)
	) u_step (
		.cur   (state_q),
		.pulse (pulse),
		.sample(adc_sample),
		.nxt   (state_nxt)
	);

	// Advance sequencer state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until the transaction on the output side completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q      <= state_nxt;
			res_gain_q <= gain_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign slot        = res_q.slot;
	assign led_compare = res_q.led_compare;
	assign red_enable  = res_q.red_on;
	assign ir_enable   = res_q.ir_on;
	assign red_level   = res_q.red_level;
	assign ir_level    = res_q.ir_level;
	assign red_count   = res_q.red_count;
	assign ir_count    = res_q.ir_count;
	assign gain_pins   = res_gain_q;

endmodule

// ===== tb/poxseq_checker.sv =====
`timescale 1ns / 1ps

module poxseq_checker #(
	parameter int SLOTS_PER_FRAME = poxseq_pkg::SLOTS_PER_FRAME_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [poxseq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [poxseq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [poxseq_pkg::SAMPLE_W-1:0]   adc_sample,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [poxseq_pkg::SLOT_W-1:0]     slot,
	input  logic [poxseq_pkg::CMP_W-1:0]      led_compare,
	input  logic                              red_enable,
	input  logic                              ir_enable,
	input  logic [poxseq_pkg::SAMPLE_W-1:0]   red_level,
	input  logic [poxseq_pkg::SAMPLE_W-1:0]   ir_level,
	input  logic [poxseq_pkg::CNT_W-1:0]      red_count,
	input  logic [poxseq_pkg::CNT_W-1:0]      ir_count,
	input  logic [poxseq_pkg::GAIN_W-1:0]     gain_pins,
	output int                                mismatches,
	output int                                pending
);
	import poxseq_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [CMP_W-1:0]    led_compare;
		logic                red_enable;
		logic                ir_enable;
		logic [SAMPLE_W-1:0] red_level;
		logic [SAMPLE_W-1:0] ir_level;
		logic [CNT_W-1:0]    red_count;
		logic [CNT_W-1:0]    ir_count;
		logic [GAIN_W-1:0]   gain_pins;
	} tick_result_t;

	// Mirror of the sequencer registers
	seq_state_t        seq;
	pulse_cfg_t        pulse;
	logic [GAIN_W-1:0] gain;
	tick_result_t      predicted_results[$];

	// Advance the slot counter by one tick and apply that slot's action
	function automatic seq_state_t advance_slot(input seq_state_t cur, input pulse_cfg_t pw,
			input logic [SAMPLE_W-1:0] sample);
		seq_state_t nxt;
		nxt = cur;
		if (int'(cur.slot) + 1 >= SLOTS_PER_FRAME)
			nxt.slot = '0;
		else
			nxt.slot = cur.slot + 1'b1;
		case (nxt.slot)
			SLOT_AMBIENT: nxt.ambient = sample;
			SLOT_RED_ON: begin
				nxt.led_compare = pw.red_pw;
				nxt.red_on = 1'b1;
			end
			SLOT_RED_SAMPLE: begin
				nxt.red_level = (sample >= cur.ambient) ? sample - cur.ambient : '0;
				nxt.red_count = cur.red_count + 1'b1;
			end
			SLOT_RED_OFF: begin
				nxt.led_compare = '0;
				nxt.red_on = 1'b0;
			end
			SLOT_IR_ON: begin
				nxt.led_compare = pw.ir_pw;
				nxt.ir_on = 1'b1;
			end
			SLOT_IR_SAMPLE: begin
				nxt.ir_level = (sample >= cur.ambient) ? sample - cur.ambient : '0;
				nxt.ir_count = cur.ir_count + 1'b1;
			end
			SLOT_IR_OFF: begin
				nxt.led_compare = '0;
				nxt.ir_on = 1'b0;
			end
			default: ;
		endcase
		return nxt;
	endfunction

	// Report one field; return 1 on a mismatch
	function automatic bit check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Track configuration, predict each tick, compare each result transaction
	always @(posedge clk or negedge arst_n) begin : track
		tick_result_t want;
		tick_result_t fresh;
		bit bad;
		if (!arst_n) begin
			seq = '0;
			pulse = '{red_pw: RED_PULSE_WIDTH_RST, ir_pw: IR_PULSE_WIDTH_RST};
			gain = GAIN_SELECT_RST;
			predicted_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			// compare the result transaction against the oldest prediction
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result transaction with no tick outstanding, slot %0d",
						$time, slot);
					mismatches <= mismatches + 1;
				end else begin
					want = predicted_results.pop_front();
					bad = 1'b0;
					bad |= check_field("slot", want.slot, slot);
					bad |= check_field("led_compare", want.led_compare, led_compare);
					bad |= check_field("red_enable", want.red_enable, red_enable);
					bad |= check_field("ir_enable", want.ir_enable, ir_enable);
					bad |= check_field("red_level", want.red_level, red_level);
					bad |= check_field("ir_level", want.ir_level, ir_level);
					bad |= check_field("red_count", want.red_count, red_count);
					bad |= check_field("ir_count", want.ir_count, ir_count);
					bad |= check_field("gain_pins", want.gain_pins, gain_pins);
					if (bad)
						mismatches <= mismatches + 1;
				end
			end

			// predict the result of an accepted tick with the settings before this edge
			if (in_valid && in_ready) begin
				seq = advance_slot(seq, pulse, adc_sample);
				fresh.slot = seq.slot;
				fresh.led_compare = seq.led_compare;
				fresh.red_enable = seq.red_on;
				fresh.ir_enable = seq.ir_on;
				fresh.red_level = seq.red_level;
				fresh.ir_level = seq.ir_level;
				fresh.red_count = seq.red_count;
				fresh.ir_count = seq.ir_count;
				fresh.gain_pins = gain;
				predicted_results.push_back(fresh);
			end

			// latch register writes; drop unknown indexes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RED_PULSE_WIDTH: pulse.red_pw = cfg_data;
					CFG_IR_PULSE_WIDTH:  pulse.ir_pw = cfg_data;
					CFG_GAIN_SELECT:     gain = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end

			pending <= predicted_results.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import poxseq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int TICKS_PER_PHASE = 250;
	localparam int FRAME_TICKS = SLOTS_PER_FRAME_DEFAULT;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   adc_sample;
	logic                  out_valid;
	logic                  out_ready;
	logic [SLOT_W-1:0]     slot;
	logic [CMP_W-1:0]      led_compare;
	logic                  red_enable;
	logic                  ir_enable;
	logic [SAMPLE_W-1:0]   red_level;
	logic [SAMPLE_W-1:0]   ir_level;
	logic [CNT_W-1:0]      red_count;
	logic [CNT_W-1:0]      ir_count;
	logic [GAIN_W-1:0]     gain_pins;

	int          mismatches;
	int          pending;
	int unsigned cycles = 0;
	bit          no_gaps = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pulse_oximeter_led_sample_sequencer_unit #(
		.SLOTS_PER_FRAME(SLOTS_PER_FRAME_DEFAULT)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.slot(slot), .led_compare(led_compare),
		.red_enable(red_enable), .ir_enable(ir_enable),
		.red_level(red_level), .ir_level(ir_level),
		.red_count(red_count), .ir_count(ir_count),
		.gain_pins(gain_pins)
	);

	poxseq_checker #(
		.SLOTS_PER_FRAME(SLOTS_PER_FRAME_DEFAULT)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .adc_sample(adc_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.slot(slot), .led_compare(led_compare),
		.red_enable(red_enable), .ir_enable(ir_enable),
		.red_level(red_level), .ir_level(ir_level),
		.red_count(red_count), .ir_count(ir_count),
		.gain_pins(gain_pins),
		.mismatches(mismatches), .pending(pending)
	);

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Converter samples: valid range, timeouts, rails and raw noise
	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SAMPLE_W'($urandom_range(0, 4095));
			4:          return '1;
			5:          return '0;
			6:          return SAMPLE_W'(4095);
			default:    return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offer one tick; hold valid and payload until the transaction is accepted
	task automatic send_tick(input logic [SAMPLE_W-1:0] value);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Write every register plus the unmapped index, then release the channel
	task automatic configure(input logic [CFG_DATA_W-1:0] red_pw,
			input logic [CFG_DATA_W-1:0] ir_pw, input logic [CFG_DATA_W-1:0] gain);
		write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
		write_reg(CFG_RED_PULSE_WIDTH, red_pw);
		write_reg(CFG_IR_PULSE_WIDTH, ir_pw);
		write_reg(CFG_GAIN_SELECT, gain);
		cfg_valid <= 1'b0;
	endtask

	// Stop ticks and wait until every predicted result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Result side: ready runs broken by random stalls
	initial begin : result_side
		int run;
		int hold;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			hold = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Tick and configuration side, then the verdict
	initial begin : stimulus
		int phase;
		int n;
		logic [SAMPLE_W-1:0] value;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		adc_sample = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one frame at reset settings: timeout as ambient, red below ambient,
		// IR timeout equal to ambient
		for (n = 0; n < FRAME_TICKS; n++) begin
			case (n)
				0:  value = '1;
				4:  value = SAMPLE_W'(4095);
				12: value = '1;
				19: value = '0;
				default: value = n[0] ? 16'hAAAA : 16'h5555;
			endcase
			send_tick(value);
		end

		// random phases, each under its own register settings
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: configure(4'd15, 4'd14, 4'd7);
				1: configure(4'd0, 4'd0, 4'd0);
				2: configure(4'd13, 4'd13, 4'd15);
				default: configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom));
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);
			for (n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) == 0)
					no_gaps = !no_gaps;
				send_tick(random_sample());
			end
		end

		wait_idle();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
rtl/poxseq_pkg.sv
rtl/poxseq_step.sv
rtl/pulse_oximeter_led_sample_sequencer_unit.sv
tb/poxseq_checker.sv
tb/tb.sv
